### rtl/gpf_pkg.sv
`default_nettype none
package gpf_pkg;

  // Field widths
  localparam int POS_W   = 32;
  localparam int MASS_W  = 32;
  localparam int G_W     = 32;
  localparam int FORCE_W = 48;
  localparam int WORD_W  = 32;

  // Derived datapath widths
  localparam int MAG_W  = POS_W + 1;                  // |other - self|
  localparam int SQ_W   = 2 * MAG_W;                  // one squared offset
  localparam int S_W    = SQ_W + 1;                   // dx^2 + dy^2
  localparam int RT_W   = (S_W + 1) / 2;              // floor(sqrt(S))
  localparam int RM_W   = 2 * RT_W;                   // root remainder
  localparam int SH_W   = (S_W + 1) / 2;              // low part of S for S*R
  localparam int GM_W   = G_W + MASS_W;
  localparam int GMM_W  = GM_W + MASS_W;
  localparam int NWORDS = GMM_W / WORD_W;
  localparam int PP_W   = WORD_W + MAG_W;             // one numerator partial product
  localparam int NUM_W  = GMM_W + MAG_W;              // G*m1*m2*|d|
  localparam int DEN_W  = S_W + RT_W + 8;             // S*R*256
  localparam int X_W    = (NUM_W > DEN_W + FORCE_W) ? NUM_W : DEN_W + FORCE_W;

  localparam logic [G_W-1:0] GRAV_RESET = G_W'(13421773);  // 0.8 in Q8.24

  localparam logic signed [FORCE_W-1:0] FORCE_MAX = {1'b0, {(FORCE_W-1){1'b1}}};
  localparam logic signed [FORCE_W-1:0] FORCE_MIN = {1'b1, {(FORCE_W-1){1'b0}}};

  typedef struct packed {
    logic signed [31:0] self_x;
    logic signed [31:0] self_y;
    logic [31:0]        self_mass;
    logic signed [31:0] other_x;
    logic signed [31:0] other_y;
    logic [31:0]        other_mass;
  } gpf_in_t;

  typedef struct packed {
    logic signed [FORCE_W-1:0] force_x;
    logic signed [FORCE_W-1:0] force_y;
    logic                      coincident;
    logic                      saturated;
  } gpf_out_t;

  // Control that rides along a divider lane
  typedef struct packed {
    logic vld;
    logic neg;
    logic coinc;
  } gpf_tag_t;

endpackage
`default_nettype wire

### rtl/gpf_div.sv
`default_nettype none
module gpf_div
  import gpf_pkg::*;
(
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire gpf_tag_t                  tag_i,
  input  wire logic [NUM_W-1:0]          num_i,
  input  wire logic [DEN_W-1:0]          den_i,
  output gpf_tag_t                       tag_o,
  output logic signed [FORCE_W-1:0]      force_o,
  output logic                           sat_o
);

  // Stage 0 holds the overflow check, stages 1..FORCE_W one quotient bit each
  gpf_tag_t           tag_q [FORCE_W+1];
  logic [NUM_W-1:0]   rem_q [FORCE_W+1];
  logic [DEN_W-1:0]   den_q [FORCE_W+1];
  logic [FORCE_W-1:0] quo_q [FORCE_W+1];
  logic               ovf_q [FORCE_W+1];

  logic ovf_d;
  assign ovf_d = X_W'(num_i) >= (X_W'(den_i) << FORCE_W);

  // Overflow stage: quotient does not fit in FORCE_W bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q[0] <= '0;
    end else begin
      tag_q[0] <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0] <= num_i;
    den_q[0] <= den_i;
    quo_q[0] <= '0;
    ovf_q[0] <= ovf_d;
  end

  // Restoring divide, most significant quotient bit first
  for (genvar k = 0; k < FORCE_W; k++) begin : g_step
    localparam int B = FORCE_W - 1 - k;
    logic [X_W-1:0]     trial;
    logic               take;
    logic [NUM_W-1:0]   rem_d;
    logic [FORCE_W-1:0] quo_d;

    always_comb begin
      trial = X_W'(den_q[k]) << B;
      take  = X_W'(rem_q[k]) >= trial;
      rem_d = take ? NUM_W'(X_W'(rem_q[k]) - trial) : rem_q[k];
      quo_d = quo_q[k];
      if (take) begin
        quo_d[B] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[k+1] <= '0;
      end else begin
        tag_q[k+1] <= tag_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= rem_d;
      den_q[k+1] <= den_q[k];
      quo_q[k+1] <= quo_d;
      ovf_q[k+1] <= ovf_q[k];
    end
  end

  // Clip, apply sign, drop coincident items to zero
  logic [FORCE_W-1:0] quo_l;
  logic               neg_l;
  logic               clip;
  logic [FORCE_W-1:0] mag;
  logic [FORCE_W-1:0] force_d;
  logic               sat_d;

  always_comb begin
    quo_l = quo_q[FORCE_W];
    neg_l = tag_q[FORCE_W].neg;
    clip  = ovf_q[FORCE_W] ||
            (quo_l[FORCE_W-1] && (!neg_l || (|quo_l[FORCE_W-2:0])));
    if (clip) begin
      mag = neg_l ? FORCE_MIN : FORCE_MAX;
    end else begin
      mag = quo_l;
    end
    force_d = neg_l ? -mag : mag;
    sat_d   = clip;
    if (tag_q[FORCE_W].coinc) begin
      force_d = '0;
      sat_d   = 1'b0;
    end
  end

  gpf_tag_t           tag_out_q;
  logic [FORCE_W-1:0] force_q;
  logic               sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_out_q <= '0;
    end else begin
      tag_out_q <= tag_q[FORCE_W];
    end
  end

  always_ff @(posedge clk_i) begin
    force_q <= force_d;
    sat_q   <= sat_d;
  end

  assign tag_o   = tag_out_q;
  assign force_o = $signed(force_q);
  assign sat_o   = sat_q;

endmodule
`default_nettype wire

### rtl/gravity_pair_force_unit.sv
// Channel  | Handshake             | Payload
// ---------+-----------------------+---------------------------------
// item     | start / busy          | item_i   (gpf_in_t)
// result   | done_o (strobe)       | result_o (gpf_out_t)
// config   | cfg_we_i              | cfg_wdata_i (G, Q8.24)
//
// One beat enters per cycle; busy is never raised. Each result passes through
// 3 offset/product stages, 34 square-root stages (one root bit each), 2 stages
// for S*R and G*m1*m2*|d|, then an overflow stage, 48 divide stages (one
// quotient bit each) and an output register.
// Reset clears the valid chain and loads G with 0.8; no stall is possible.
`default_nettype none
module gravity_pair_force_unit
  import gpf_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  output logic                busy,
  input  wire gpf_in_t        item_i,
  output logic                done_o,
  output gpf_out_t            result_o,
  input  wire logic           cfg_we_i,
  input  wire logic [G_W-1:0] cfg_wdata_i
);

  // Gravitational constant
  logic [G_W-1:0] grav_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grav_q <= GRAV_RESET;
    end else if (cfg_we_i) begin
      grav_q <= cfg_wdata_i;
    end
  end

  assign busy = 1'b0;

  // Stage 1: offsets, magnitudes, G*m1
  logic signed [POS_W:0] dx_d, dy_d;
  logic                  v1_q, nx1_q, ny1_q;
  logic [MAG_W-1:0]      ax1_q, ay1_q;
  logic [GM_W-1:0]       gm1_q;
  logic [MASS_W-1:0]     m2_1_q;

  assign dx_d = {item_i.other_x[POS_W-1], item_i.other_x[POS_W-1:0]}
              - {item_i.self_x[POS_W-1], item_i.self_x[POS_W-1:0]};
  assign dy_d = {item_i.other_y[POS_W-1], item_i.other_y[POS_W-1:0]}
              - {item_i.self_y[POS_W-1], item_i.self_y[POS_W-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    nx1_q  <= dx_d[POS_W];
    ny1_q  <= dy_d[POS_W];
    ax1_q  <= dx_d[POS_W] ? MAG_W'(-dx_d) : MAG_W'(dx_d);
    ay1_q  <= dy_d[POS_W] ? MAG_W'(-dy_d) : MAG_W'(dy_d);
    gm1_q  <= GM_W'(grav_q) * GM_W'(item_i.self_mass);
    m2_1_q <= item_i.other_mass;
  end

  // Stage 2: squares and the two halves of G*m1*m2
  logic                v2_q, nx2_q, ny2_q;
  logic [MAG_W-1:0]    ax2_q, ay2_q;
  logic [SQ_W-1:0]     sx2_q, sy2_q;
  logic [GM_W-1:0]     gml2_q, gmh2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    nx2_q  <= nx1_q;
    ny2_q  <= ny1_q;
    ax2_q  <= ax1_q;
    ay2_q  <= ay1_q;
    sx2_q  <= SQ_W'(ax1_q) * SQ_W'(ax1_q);
    sy2_q  <= SQ_W'(ay1_q) * SQ_W'(ay1_q);
    gml2_q <= GM_W'(gm1_q[G_W-1:0]) * GM_W'(m2_1_q);
    gmh2_q <= GM_W'(gm1_q[GM_W-1:G_W]) * GM_W'(m2_1_q);
  end

  // Stage 3: S and G*m1*m2
  logic                v3_q, nx3_q, ny3_q;
  logic [MAG_W-1:0]    ax3_q, ay3_q;
  logic [S_W-1:0]      s3_q;
  logic [GMM_W-1:0]    gmm3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    nx3_q  <= nx2_q;
    ny3_q  <= ny2_q;
    ax3_q  <= ax2_q;
    ay3_q  <= ay2_q;
    s3_q   <= S_W'(sx2_q) + S_W'(sy2_q);
    gmm3_q <= GMM_W'(gml2_q) + (GMM_W'(gmh2_q) << G_W);
  end

  // Square root, one root bit per stage
  logic                v_r   [RT_W+1];
  logic                nx_r  [RT_W+1];
  logic                ny_r  [RT_W+1];
  logic [MAG_W-1:0]    ax_r  [RT_W+1];
  logic [MAG_W-1:0]    ay_r  [RT_W+1];
  logic [S_W-1:0]      s_r   [RT_W+1];
  logic [GMM_W-1:0]    gmm_r [RT_W+1];
  logic [RM_W-1:0]     rem_r [RT_W+1];
  logic [RT_W-1:0]     root_r[RT_W+1];

  assign v_r[0]    = v3_q;
  assign nx_r[0]   = nx3_q;
  assign ny_r[0]   = ny3_q;
  assign ax_r[0]   = ax3_q;
  assign ay_r[0]   = ay3_q;
  assign s_r[0]    = s3_q;
  assign gmm_r[0]  = gmm3_q;
  assign rem_r[0]  = RM_W'(s3_q);
  assign root_r[0] = '0;

  for (genvar k = 0; k < RT_W; k++) begin : g_sqrt
    localparam int B = RT_W - 1 - k;
    logic [RM_W-1:0] trial;
    logic            take;
    logic [RT_W-1:0] root_d;

    always_comb begin
      trial  = (RM_W'(root_r[k]) << (B + 1)) | (RM_W'(1) << (2 * B));
      take   = rem_r[k] >= trial;
      root_d = root_r[k];
      if (take) begin
        root_d[B] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_r[k+1] <= 1'b0;
      end else begin
        v_r[k+1] <= v_r[k];
      end
    end

    always_ff @(posedge clk_i) begin
      nx_r[k+1]   <= nx_r[k];
      ny_r[k+1]   <= ny_r[k];
      ax_r[k+1]   <= ax_r[k];
      ay_r[k+1]   <= ay_r[k];
      s_r[k+1]    <= s_r[k];
      gmm_r[k+1]  <= gmm_r[k];
      rem_r[k+1]  <= take ? rem_r[k] - trial : rem_r[k];
      root_r[k+1] <= root_d;
    end
  end

  // Partial products of S*R and G*m1*m2*|d|
  localparam int DP_W = SH_W + RT_W;
  logic             vp_q, nxp_q, nyp_q, cop_q;
  logic [DP_W-1:0]  dlo_q, dhi_q;
  logic [PP_W-1:0]  ppx_q [NWORDS];
  logic [PP_W-1:0]  ppy_q [NWORDS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else begin
      vp_q <= v_r[RT_W];
    end
  end

  always_ff @(posedge clk_i) begin
    nxp_q <= nx_r[RT_W];
    nyp_q <= ny_r[RT_W];
    cop_q <= (s_r[RT_W] == '0);
    dlo_q <= DP_W'(s_r[RT_W][SH_W-1:0]) * DP_W'(root_r[RT_W]);
    dhi_q <= DP_W'(s_r[RT_W] >> SH_W) * DP_W'(root_r[RT_W]);
  end

  for (genvar w = 0; w < NWORDS; w++) begin : g_pp
    always_ff @(posedge clk_i) begin
      ppx_q[w] <= PP_W'(gmm_r[RT_W][w*WORD_W +: WORD_W]) * PP_W'(ax_r[RT_W]);
      ppy_q[w] <= PP_W'(gmm_r[RT_W][w*WORD_W +: WORD_W]) * PP_W'(ay_r[RT_W]);
    end
  end

  // Sum partial products into numerators and denominator
  logic [NUM_W-1:0] numx_d, numy_d;
  always_comb begin
    numx_d = '0;
    numy_d = '0;
    for (int w = 0; w < NWORDS; w++) begin
      numx_d = numx_d + (NUM_W'(ppx_q[w]) << (w * WORD_W));
      numy_d = numy_d + (NUM_W'(ppy_q[w]) << (w * WORD_W));
    end
  end

  gpf_tag_t          tagx_q, tagy_q;
  logic [NUM_W-1:0]  numx_q, numy_q;
  logic [DEN_W-1:0]  den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tagx_q <= '0;
      tagy_q <= '0;
    end else begin
      tagx_q <= '{vld: vp_q, neg: nxp_q, coinc: cop_q};
      tagy_q <= '{vld: vp_q, neg: nyp_q, coinc: cop_q};
    end
  end

  always_ff @(posedge clk_i) begin
    numx_q <= numx_d;
    numy_q <= numy_d;
    den_q  <= ((DEN_W'(dhi_q) << SH_W) + DEN_W'(dlo_q)) << 8;
  end

  // Divider lanes, one per component
  gpf_tag_t                  tagx_o, tagy_o;
  logic signed [FORCE_W-1:0] fx, fy;
  logic                      satx, saty;

  gpf_div u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (tagx_q),
    .num_i   (numx_q),
    .den_i   (den_q),
    .tag_o   (tagx_o),
    .force_o (fx),
    .sat_o   (satx)
  );

  gpf_div u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (tagy_q),
    .num_i   (numy_q),
    .den_i   (den_q),
    .tag_o   (tagy_o),
    .force_o (fy),
    .sat_o   (saty)
  );

  // Merge the lanes into one result beat
  assign done_o              = tagx_o.vld && tagy_o.vld;
  assign result_o.force_x    = fx;
  assign result_o.force_y    = fy;
  assign result_o.coincident = tagx_o.coinc;
  assign result_o.saturated  = satx || saty;

endmodule
`default_nettype wire

### rtl/gpf_checker.sv
`default_nettype none
module gpf_checker
  import gpf_pkg::*;
(
  input wire logic     clk_i,
  input wire logic     rst_ni,
  input wire logic     start,
  input wire logic     busy,
  input wire logic     done_o,
  input wire gpf_out_t result_o
);

  // Pipeline never pushes back on the sender
  a_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");

  // Coincident bodies give zero force and no clip
  a_coinc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.coincident |->
      result_o.force_x == '0 && result_o.force_y == '0 && !result_o.saturated)
    else $error("coincident beat with nonzero force");

  // A clipped beat shows a rail value on some component
  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.saturated |->
      result_o.force_x == FORCE_MAX || result_o.force_x == FORCE_MIN ||
      result_o.force_y == FORCE_MAX || result_o.force_y == FORCE_MIN)
    else $error("saturated beat without rail value");

  // No beat right after reset release
  a_quiet_reset: assert property (@(posedge clk_i) $rose(rst_ni) |-> !done_o)
    else $error("result beat out of reset");

  // Nothing accepted means nothing to deliver shortly after reset
  a_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !start && !$past(start) && $past(rst_ni, 2) == 1'b0 |-> !done_o)
    else $error("result without accepted beat");

endmodule

bind gravity_pair_force_unit gpf_checker u_gpf_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);
`default_nettype wire

### dv/gravity_pair_force_checker.sv
`timescale 1ns / 1ps
module gravity_pair_force_checker
  import gpf_pkg::*;
(
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           start,
  input  wire logic           busy,
  input  wire gpf_in_t        item_i,
  input  wire logic           done_o,
  input  wire gpf_out_t       result_o,
  input  wire logic           cfg_we_i,
  input  wire logic [G_W-1:0] cfg_wdata_i,
  output int                  err_count,
  output int                  pending
);

  typedef logic [255:0] wide_t;

  logic [G_W-1:0] grav_q;
  gpf_out_t       force_q[$];

  // Clip one component magnitude to the signed range and apply the sign
  function automatic logic [FORCE_W-1:0] clip_component(wide_t quot, logic neg,
                                                        ref logic sat);
    wide_t lim;
    wide_t mag;
    lim = neg ? (wide_t'(1) << (FORCE_W - 1)) : ((wide_t'(1) << (FORCE_W - 1)) - 1);
    mag = quot;
    if (quot > lim) begin
      mag = lim;
      sat = 1'b1;
    end
    return neg ? FORCE_W'(-mag) : FORCE_W'(mag);
  endfunction

  // Inverse-square pull of the other body on self, with floor square root
  function automatic gpf_out_t pair_force(gpf_in_t it, logic [G_W-1:0] g);
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic [32:0]        ax;
    logic [32:0]        ay;
    wide_t              s;
    wide_t              cand;
    logic [63:0]        root;
    wide_t              den;
    wide_t              gmm;
    logic               sat;
    gpf_out_t           res;
    dx   = {it.other_x[31], it.other_x} - {it.self_x[31], it.self_x};
    dy   = {it.other_y[31], it.other_y} - {it.self_y[31], it.self_y};
    ax   = dx[32] ? 33'(-dx) : 33'(dx);
    ay   = dy[32] ? 33'(-dy) : 33'(dy);
    s    = wide_t'(ax) * wide_t'(ax) + wide_t'(ay) * wide_t'(ay);
    res  = '0;
    sat  = 1'b0;
    if (s == 0) begin
      res.coincident = 1'b1;
      return res;
    end
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = wide_t'(root | (64'd1 << b));
      if (cand * cand <= s) root = cand[63:0];
    end
    den = s * wide_t'(root) * 256;
    gmm = wide_t'(g) * wide_t'(it.self_mass) * wide_t'(it.other_mass);
    res.force_x   = clip_component((gmm * wide_t'(ax)) / den, dx[32], sat);
    res.force_y   = clip_component((gmm * wide_t'(ay)) / den, dy[32], sat);
    res.saturated = sat;
    return res;
  endfunction

  assign pending = force_q.size();

  // Predict on each accepted beat, compare each result beat, track G
  always @(posedge clk_i or negedge rst_ni) begin
    gpf_out_t want;
    if (!rst_ni) begin
      grav_q    <= GRAV_RESET;
      err_count <= 0;
      force_q.delete();
    end else begin
      if (start && !busy) force_q.push_back(pair_force(item_i, grav_q));
      if (done_o) begin
        if (force_q.size() == 0) begin
          if (err_count < 10) $display("unexpected result beat %p", result_o);
          err_count <= err_count + 1;
        end else begin
          want = force_q.pop_front();
          if (want.force_x !== result_o.force_x || want.force_y !== result_o.force_y ||
              want.coincident !== result_o.coincident ||
              want.saturated !== result_o.saturated) begin
            if (err_count < 10)
              $display("result differs: expected %p, got %p", want, result_o);
            err_count <= err_count + 1;
          end
        end
      end
      if (cfg_we_i) grav_q <= cfg_wdata_i;
    end
  end

endmodule

### dv/gravity_pair_force_unit_test.sv
`timescale 1ns / 1ps
module gravity_pair_force_unit_test;
  import gpf_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 120;

  logic           clk_i;
  logic           rst_ni;
  logic           start;
  logic           busy;
  gpf_in_t        item_i;
  logic           done_o;
  gpf_out_t       result_o;
  logic           cfg_we_i;
  logic [G_W-1:0] cfg_wdata_i;
  int             err_count;
  int             pending;
  int             cycle_cnt = 0;
  int             idle_pct;

  gravity_pair_force_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  gravity_pair_force_checker u_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .err_count  (err_count),
    .pending    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("gravity_pair_force_unit: mismatch");
      $finish;
    end
  end

  // Send one beat, with a random gap ahead of it
  task automatic send_pair(gpf_in_t it);
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < 40) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
  endtask

  // Hold off until every expected result has come, then let the pipe empty
  task automatic drain_pipe();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_grav(logic [G_W-1:0] g);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= g;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  function automatic gpf_in_t make_pair(logic signed [31:0] sx, logic signed [31:0] sy,
                                        logic [31:0] sm, logic signed [31:0] ox,
                                        logic signed [31:0] oy, logic [31:0] om);
    gpf_in_t it;
    it = '{self_x: sx, self_y: sy, self_mass: sm, other_x: ox, other_y: oy,
           other_mass: om};
    return it;
  endfunction

  // Mostly nearby pairs with varied masses, some fully random noise, some coincident or axis-aligned
  function automatic gpf_in_t random_pair();
    gpf_in_t it;
    int      spread;
    it = make_pair($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    case ($urandom_range(4))
      0: ;
      1: begin
        spread = $urandom_range(20, 1);
        it.other_x = it.self_x + ($signed($urandom) >>> (32 - spread));
        it.other_y = it.self_y + ($signed($urandom) >>> (32 - spread));
      end
      2: begin
        it.other_x = it.self_x + $signed($urandom_range(65536 * 4)) - 131072;
        it.other_y = it.self_y;
        it.self_mass  = $urandom >> $urandom_range(31);
        it.other_mass = $urandom >> $urandom_range(31);
      end
      3: begin
        spread = $urandom_range(31, 8);
        it.other_x = it.self_x + ($signed($urandom) >>> (32 - spread));
        it.other_y = it.self_y + ($signed($urandom) >>> (32 - spread));
        it.self_mass  = $urandom >> $urandom_range(31, 8);
        it.other_mass = $urandom >> $urandom_range(31, 8);
      end
      default: begin
        it.other_x = it.self_x;
        if ($urandom_range(1)) it.other_y = it.self_y;
      end
    endcase
    return it;
  endfunction

  initial begin
    logic [G_W-1:0] grav_set[6];
    idle_pct    = 0;
    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats at reset G: extremes, coincidence, saturation, zero mass
    send_pair(make_pair(0, 0, 32'h10000, 0, 0, 32'h10000));
    send_pair(make_pair(32'h7fffffff, 32'h7fffffff, '1, 32'h7fffffff, 32'h7fffffff, '1));
    send_pair(make_pair(32'h80000000, 32'h80000000, '1, 32'h7fffffff, 32'h7fffffff, '1));
    send_pair(make_pair(32'h7fffffff, 32'h80000000, '1, 32'h80000000, 32'h7fffffff, '1));
    send_pair(make_pair(0, 0, '1, 1, 0, '1));
    send_pair(make_pair(0, 0, '1, -1, 0, '1));
    send_pair(make_pair(0, 0, '1, 0, 1, '1));
    send_pair(make_pair(0, 0, '1, 1, -1, '1));
    send_pair(make_pair(0, 0, 0, 32'h10000, 0, '1));
    send_pair(make_pair(0, 0, '1, 32'h10000, 32'h10000, 0));
    send_pair(make_pair(32'h10000, 0, 32'h10000, 0, 0, 32'h10000));
    send_pair(make_pair(0, 32'h30000, 32'h20000, 32'h40000, 0, 32'h50000));
    send_pair(make_pair(-5, 7, 32'h8000, -5, 7, 32'h8000));
    drain_pipe();

    // Phases over G settings and idle rates
    grav_set[0] = '0;
    grav_set[1] = '1;
    grav_set[2] = $urandom;
    grav_set[3] = 32'd1;
    grav_set[4] = GRAV_RESET;
    grav_set[5] = $urandom >> $urandom_range(31);
    for (int ph = 0; ph < 6; ph++) begin
      write_grav(grav_set[ph]);
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 82;
        2: idle_pct = 10;
        default: idle_pct = 0;
      endcase
      for (int n = 0; n < 65; n++) begin
        send_pair(random_pair());
        if (ph == 2 && n == 30) drain_pipe();
      end
      drain_pipe();
    end

    if (err_count == 0 && pending == 0) begin
      $display("gravity_pair_force_unit: match");
    end else begin
      $display("gravity_pair_force_unit: mismatch");
    end
    $finish;
  end

endmodule
